// File: rtl/pccv_pkg.sv
package pccv_pkg;

    // class codes as they leave the block
    typedef logic [2:0] t_class;

    localparam int     NUM_CLASSES = 6;
    localparam t_class CLASS_A     = 3'd0;
    localparam t_class CLASS_C     = 3'd1;
    localparam t_class CLASS_G     = 3'd2;
    localparam t_class CLASS_T     = 3'd3;
    localparam t_class CLASS_N     = 3'd4;
    localparam t_class CLASS_GAP   = 3'd5;

    // observation kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ABSENT = 2'd0;
    localparam t_kind KIND_BASE   = 2'd1;
    localparam t_kind KIND_GAP    = 2'd2;

    // packed base codes that map to a real base
    localparam logic [3:0] CODE_A = 4'd1;
    localparam logic [3:0] CODE_C = 4'd2;
    localparam logic [3:0] CODE_G = 4'd4;
    localparam logic [3:0] CODE_T = 4'd8;

    // output count width and its saturation point
    localparam int OUT_WIDTH = 16;

endpackage

// File: rtl/pccv_accum.sv
// Input register, per-class vote counters and the end-of-column snapshot.
module pccv_accum #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // observation channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_obs_kind,
    input  logic [3:0]             i_base_code,
    input  logic [7:0]             i_base_quality,
    input  logic                   i_last_of_column,
    // snapshot channel toward the decision stage
    output logic                   o_snap_valid,
    input  logic                   i_snap_ready,
    output logic [COUNT_WIDTH-1:0] o_snap_count [pccv_pkg::NUM_CLASSES],
    output logic [7:0]             o_snap_qual  [pccv_pkg::NUM_CLASSES]
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic [3:0] r_code;
    logic [7:0] r_qual;
    logic       r_last;

    // running column state
    logic [COUNT_WIDTH-1:0] r_count [pccv_pkg::NUM_CLASSES];
    logic [7:0]             r_best  [pccv_pkg::NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] n_count [pccv_pkg::NUM_CLASSES];
    logic [7:0]             n_best  [pccv_pkg::NUM_CLASSES];

    // snapshot register
    logic                   r_snap_valid;
    logic [COUNT_WIDTH-1:0] r_snap_count [pccv_pkg::NUM_CLASSES];
    logic [7:0]             r_snap_qual  [pccv_pkg::NUM_CLASSES];

    logic                snap_free;
    logic                in_adv;
    logic                vote;
    pccv_pkg::t_class    vote_cls;
    logic [7:0]          vote_qual;

    // a non-last beat always drains into the counters
    assign snap_free = !r_snap_valid || i_snap_ready;
    assign in_adv    = r_in_valid && (!r_last || snap_free);
    assign o_ready   = !r_in_valid || in_adv;

    // classify the registered observation
    always_comb begin
        vote      = 1'b0;
        vote_cls  = pccv_pkg::CLASS_N;
        vote_qual = 8'd0;
        case (r_kind)
            pccv_pkg::KIND_BASE: begin
                vote      = 1'b1;
                vote_qual = r_qual;
                case (r_code)
                    pccv_pkg::CODE_A: vote_cls = pccv_pkg::CLASS_A;
                    pccv_pkg::CODE_C: vote_cls = pccv_pkg::CLASS_C;
                    pccv_pkg::CODE_G: vote_cls = pccv_pkg::CLASS_G;
                    pccv_pkg::CODE_T: vote_cls = pccv_pkg::CLASS_T;
                    default:          vote_cls = pccv_pkg::CLASS_N;
                endcase
            end
            pccv_pkg::KIND_GAP: begin
                // gap votes carry quality 0
                vote     = 1'b1;
                vote_cls = pccv_pkg::CLASS_GAP;
            end
            default: vote = 1'b0;
        endcase
    end

    // counters with the current vote applied, saturating
    always_comb begin
        for (int i = 0; i < pccv_pkg::NUM_CLASSES; i++) begin
            n_count[i] = r_count[i];
            n_best[i]  = r_best[i];
            if (vote && vote_cls == 3'(i)) begin
                if (r_count[i] != COUNT_MAX) begin
                    n_count[i] = r_count[i] + 1'b1;
                end
                if (vote_qual > r_best[i]) begin
                    n_best[i] = vote_qual;
                end
            end
        end
    end

    // input register load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready) begin
            r_kind <= i_obs_kind;
            r_code <= i_base_code;
            r_qual <= i_base_quality;
            r_last <= i_last_of_column;
        end
    end

    // column state: update on every beat, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pccv_pkg::NUM_CLASSES; i++) begin
                r_count[i] <= '0;
                r_best[i]  <= '0;
            end
        end else if (in_adv) begin
            for (int i = 0; i < pccv_pkg::NUM_CLASSES; i++) begin
                r_count[i] <= r_last ? '0 : n_count[i];
                r_best[i]  <= r_last ? '0 : n_best[i];
            end
        end
    end

    // snapshot of the finished column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= in_adv && r_last;
        end
        if (snap_free && in_adv && r_last) begin
            for (int i = 0; i < pccv_pkg::NUM_CLASSES; i++) begin
                r_snap_count[i] <= n_count[i];
                r_snap_qual[i]  <= n_best[i];
            end
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap_count = r_snap_count;
    assign o_snap_qual  = r_snap_qual;

endmodule

// File: rtl/pccv_decide.sv
// Majority pick, 0.6 rule and the result register.
module pccv_decide #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // snapshot channel
    input  logic                   i_snap_valid,
    output logic                   o_snap_ready,
    input  logic [COUNT_WIDTH-1:0] i_snap_count [pccv_pkg::NUM_CLASSES],
    input  logic [7:0]             i_snap_qual  [pccv_pkg::NUM_CLASSES],
    // result channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0]             o_consensus_class,
    output logic [7:0]             o_consensus_quality,
    output logic [15:0]            o_consensus_count,
    output logic [15:0]            o_total_count
);

    // total of six counters needs three extra bits
    localparam int TW = COUNT_WIDTH + 3;
    // width for the output saturation compare
    localparam int SW = (TW > pccv_pkg::OUT_WIDTH) ? TW : pccv_pkg::OUT_WIDTH + 1;
    localparam logic [SW-1:0] OUT_MAX = SW'({pccv_pkg::OUT_WIDTH{1'b1}});

    logic                   out_free;
    logic                   snap_adv;
    pccv_pkg::t_class       best_cls;
    logic [COUNT_WIDTH-1:0] best_cnt;
    logic [TW-1:0]          total;
    logic [TW+1:0]          best_x5;
    logic [TW+1:0]          total_x3;
    logic                   wins;
    pccv_pkg::t_class       cls;
    logic [7:0]             qual;
    logic [SW-1:0]          cls_cnt_x;
    logic [SW-1:0]          total_x;

    logic        r_valid;
    logic [2:0]  r_class;
    logic [7:0]  r_qual;
    logic [15:0] r_cons_cnt;
    logic [15:0] r_total;

    assign out_free     = !r_valid || i_ready;
    assign snap_adv     = i_snap_valid && out_free;
    assign o_snap_ready = out_free;

    // first strict maximum, and the column total
    always_comb begin
        best_cls = pccv_pkg::CLASS_A;
        best_cnt = '0;
        total    = '0;
        for (int i = 0; i < pccv_pkg::NUM_CLASSES; i++) begin
            if (i_snap_count[i] > best_cnt) begin
                best_cls = 3'(i);
                best_cnt = i_snap_count[i];
            end
            total = total + TW'(i_snap_count[i]);
        end
    end

    // count*5 >= total*3, by shift and add
    assign best_x5  = ((TW+2)'(best_cnt) << 2) + (TW+2)'(best_cnt);
    assign total_x3 = ((TW+2)'(total) << 1) + (TW+2)'(total);
    assign wins     = (total != '0) && (best_x5 >= total_x3);

    // call: winner, or N on disagreement or an empty column
    always_comb begin
        if (wins) begin
            cls  = best_cls;
            qual = i_snap_qual[best_cls];
        end else begin
            cls  = pccv_pkg::CLASS_N;
            qual = 8'd0;
        end
        cls_cnt_x = SW'(i_snap_count[cls]);
        total_x   = SW'(total);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= i_snap_valid;
        end
        if (snap_adv) begin
            r_class    <= cls;
            r_qual     <= qual;
            r_cons_cnt <= (cls_cnt_x > OUT_MAX) ? 16'hFFFF : cls_cnt_x[15:0];
            r_total    <= (total_x > OUT_MAX) ? 16'hFFFF : total_x[15:0];
        end
    end

    assign o_valid             = r_valid;
    assign o_consensus_class   = r_class;
    assign o_consensus_quality = r_qual;
    assign o_consensus_count   = r_cons_cnt;
    assign o_total_count       = r_total;

endmodule

// File: rtl/pileup_column_consensus_voter.sv
// Channel      Handshake           Payload
// observation  i_valid / o_ready   i_obs_kind, i_base_code, i_base_quality, i_last_of_column
// consensus    o_valid / i_ready   o_consensus_class, o_consensus_quality,
//                                  o_consensus_count, o_total_count
//
// One observation beat per cycle unless stalled, through three register stages:
// input register, column snapshot, result register. A column's result shows
// on o_valid once its last beat has passed the snapshot and the result register.
// Synchronous active-low reset clears the counters and all valid flags.
// Input stalls only while a last beat sits in the input register with the
// snapshot and the result register both full and the result not taken.
module pileup_column_consensus_voter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_obs_kind,
    input  logic [3:0]  i_base_code,
    input  logic [7:0]  i_base_quality,
    input  logic        i_last_of_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_consensus_class,
    output logic [7:0]  o_consensus_quality,
    output logic [15:0] o_consensus_count,
    output logic [15:0] o_total_count
);

    logic                   snap_valid;
    logic                   snap_ready;
    logic [COUNT_WIDTH-1:0] snap_count [pccv_pkg::NUM_CLASSES];
    logic [7:0]             snap_qual  [pccv_pkg::NUM_CLASSES];

    // vote counting
    pccv_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_obs_kind       (i_obs_kind),
        .i_base_code      (i_base_code),
        .i_base_quality   (i_base_quality),
        .i_last_of_column (i_last_of_column),
        .o_snap_valid     (snap_valid),
        .i_snap_ready     (snap_ready),
        .o_snap_count     (snap_count),
        .o_snap_qual      (snap_qual)
    );

    // consensus call
    pccv_decide #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decide (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_snap_valid        (snap_valid),
        .o_snap_ready        (snap_ready),
        .i_snap_count        (snap_count),
        .i_snap_qual         (snap_qual),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_consensus_class   (o_consensus_class),
        .o_consensus_quality (o_consensus_quality),
        .o_consensus_count   (o_consensus_count),
        .o_total_count       (o_total_count)
    );

endmodule
